FILE: rtl/lwc_pkg.sv
// Shared types and codes for the line window clipper.
// No dependencies.
package lwc_pkg;

    // Outcode bits
    localparam logic [3:0] OC_TOP    = 4'd8;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_LEFT   = 4'd1;

    // Config register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Most edge moves before a forced reject
    localparam logic [2:0] CLIP_LIMIT = 3'd4;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DLOAD = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage

FILE: rtl/lwc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module lwc_div #(
    parameter int DW = 41,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [VW:0]     trial;
    logic            fits;

    // Trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? VW'(trial - {1'b0, r_den}) : trial[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/line_window_clipper.sv
// Top level of the line window clipper: config registers, sequencer, shared
// multiply and divide. Depends on lwc_pkg and lwc_div.
//
// Channel  | Handshake              | Beat
// ---------+------------------------+-----------------------------------
// input    | start & !busy          | x_start, y_start, x_end, y_end
// result   | o_valid, one cycle     | visible, four clipped coords, codes
// config   | i_cfg_valid&o_cfg_ready| register index and data
//
// A segment holds busy through evaluation and, per edge move (up to four),
// a multiply, a divider load and a divide by the one-bit-per-cycle divider;
// a move with a zero divisor skips the multiply and divide.
// The result beat appears in the same cycle that busy drops.
// Synchronous active-low reset loads the default window; results cannot
// be stalled, each shows for exactly one cycle. Config is always ready.
module line_window_clipper
    import lwc_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_x_start,
    input  logic signed [COORD_BITS-1:0]        i_y_start,
    input  logic signed [COORD_BITS-1:0]        i_x_end,
    input  logic signed [COORD_BITS-1:0]        i_y_end,
    output logic                                o_valid,
    output logic                                o_visible,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_clipped_x_start,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_clipped_y_start,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_clipped_x_end,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] o_clipped_y_end,
    output logic [3:0]                          o_start_outcode,
    output logic [3:0]                          o_end_outcode,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [COORD_BITS-1:0]               i_cfg_data
);
    localparam int CW = COORD_BITS;
    localparam int FW = COORD_BITS + FRAC_BITS;
    localparam int MW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 1;
    localparam int DW = PW + FRAC_BITS;

    // Window registers
    logic signed [CW-1:0] r_win_left, r_win_bottom, r_win_right, r_win_top;

    // Segment state
    t_state               r_state;
    logic signed [CW-1:0] r_xs, r_ys, r_xe, r_ye;
    logic signed [FW-1:0] r_px0, r_py0, r_px1, r_py1;
    logic [3:0]           r_oc0, r_oc1;
    logic [2:0]           r_iter;
    logic                 r_k, r_vert, r_neg;
    logic signed [CW-1:0] r_base;
    logic [MW-1:0]        r_num_mag, r_del_mag, r_den_mag;
    logic [PW-1:0]        r_prod;

    // Result registers
    logic                 r_valid, r_visible, r_ovis;
    logic signed [FW-1:0] r_ox0, r_oy0, r_ox1, r_oy1;
    logic [3:0]           r_ooc0, r_ooc1;

    logic signed [FW-1:0] wl_f, wb_f, wr_f, wt_f;
    logic [3:0]           c0, c1, c_sel;
    logic                 div_done;
    logic [DW-1:0]        div_quot;
    logic signed [FW-1:0] base_f, cross_res;
    logic signed [CW-1:0] edge_v, base_v;
    logic signed [MW-1:0] num_s, del_s, den_s;
    logic                 vert;

    function automatic logic [MW-1:0] f_mag(input logic signed [MW-1:0] v);
        f_mag = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic [3:0] f_code(input logic signed [FW-1:0] x,
                                          input logic signed [FW-1:0] y,
                                          input logic signed [FW-1:0] l,
                                          input logic signed [FW-1:0] b,
                                          input logic signed [FW-1:0] r,
                                          input logic signed [FW-1:0] t);
        logic [3:0] c;
        c = '0;
        if (y > t) c = c | OC_TOP;
        if (y < b) c = c | OC_BOTTOM;
        if (x > r) c = c | OC_RIGHT;
        if (x < l) c = c | OC_LEFT;
        f_code = c;
    endfunction

    // Window edges in fixed point
    assign wl_f = FW'(r_win_left)   <<< FRAC_BITS;
    assign wb_f = FW'(r_win_bottom) <<< FRAC_BITS;
    assign wr_f = FW'(r_win_right)  <<< FRAC_BITS;
    assign wt_f = FW'(r_win_top)    <<< FRAC_BITS;

    assign c0 = f_code(r_px0, r_py0, wl_f, wb_f, wr_f, wt_f);
    assign c1 = f_code(r_px1, r_py1, wl_f, wb_f, wr_f, wt_f);
    assign c_sel = (c0 != 4'd0) ? c0 : c1;

    // Edge choice and operands for the next move
    always_comb begin
        vert   = 1'b0;
        edge_v = r_win_left;
        priority if ((c_sel & OC_TOP) != 4'd0) begin
            edge_v = r_win_top;
        end else if ((c_sel & OC_BOTTOM) != 4'd0) begin
            edge_v = r_win_bottom;
        end else if ((c_sel & OC_RIGHT) != 4'd0) begin
            vert   = 1'b1;
            edge_v = r_win_right;
        end else begin
            vert   = 1'b1;
            edge_v = r_win_left;
        end
        if (vert) begin
            base_v = r_ys;
            num_s  = MW'(r_ye) - MW'(r_ys);
            del_s  = MW'(edge_v) - MW'(r_xs);
            den_s  = MW'(r_xe) - MW'(r_xs);
        end else begin
            base_v = r_xs;
            num_s  = MW'(r_xe) - MW'(r_xs);
            del_s  = MW'(edge_v) - MW'(r_ys);
            den_s  = MW'(r_ye) - MW'(r_ys);
        end
    end

    // Intersection from the quotient
    assign base_f    = FW'(r_base) <<< FRAC_BITS;
    assign cross_res = r_neg ? FW'(base_f - FW'(div_quot)) : FW'(base_f + FW'(div_quot));

    lwc_div #(
        .DW(DW),
        .VW(MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DLOAD),
        .i_dividend (DW'(r_prod) << FRAC_BITS),
        .i_divisor  (r_den_mag),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= CW'(50);
            r_win_bottom <= CW'(50);
            r_win_right  <= CW'(200);
            r_win_top    <= CW'(200);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEFT:   r_win_left   <= i_cfg_data;
                REG_BOTTOM: r_win_bottom <= i_cfg_data;
                REG_RIGHT:  r_win_right  <= i_cfg_data;
                REG_TOP:    r_win_top    <= i_cfg_data;
                default:    r_win_top    <= r_win_top;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_state <= S_EVAL;
                    r_iter  <= '0;
                end
                S_EVAL: begin
                    if (((c0 | c1) == 4'd0) || ((c0 & c1) != 4'd0) || (r_iter == CLIP_LIMIT)) begin
                        r_state <= S_OUT;
                    end else if (den_s == '0) begin
                        r_iter <= r_iter + 3'd1;
                    end else begin
                        r_state <= S_MUL;
                        r_iter  <= r_iter + 3'd1;
                    end
                end
                S_MUL:   r_state <= S_DLOAD;
                S_DLOAD: r_state <= S_DIV;
                S_DIV:   if (div_done) r_state <= S_EVAL;
                S_OUT: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (start) begin
                r_xs  <= i_x_start;
                r_ys  <= i_y_start;
                r_xe  <= i_x_end;
                r_ye  <= i_y_end;
                r_px0 <= FW'(i_x_start) <<< FRAC_BITS;
                r_py0 <= FW'(i_y_start) <<< FRAC_BITS;
                r_px1 <= FW'(i_x_end)   <<< FRAC_BITS;
                r_py1 <= FW'(i_y_end)   <<< FRAC_BITS;
            end
            S_EVAL: begin
                if (r_iter == 3'd0) begin
                    r_oc0 <= c0;
                    r_oc1 <= c1;
                end
                r_visible <= ((c0 | c1) == 4'd0);
                r_k       <= (c0 == 4'd0);
                r_vert    <= vert;
                r_base    <= base_v;
                r_num_mag <= f_mag(num_s);
                r_del_mag <= f_mag(del_s);
                r_den_mag <= f_mag(den_s);
                r_neg     <= num_s[MW-1] ^ del_s[MW-1] ^ den_s[MW-1];
                // Edge coordinate is exact; zero divisor keeps the start value
                if (((c0 | c1) != 4'd0) && ((c0 & c1) == 4'd0) && (r_iter != CLIP_LIMIT)) begin
                    if (c0 != 4'd0) begin
                        if (vert) begin
                            r_px0 <= FW'(edge_v) <<< FRAC_BITS;
                            if (den_s == '0) r_py0 <= FW'(base_v) <<< FRAC_BITS;
                        end else begin
                            r_py0 <= FW'(edge_v) <<< FRAC_BITS;
                            if (den_s == '0) r_px0 <= FW'(base_v) <<< FRAC_BITS;
                        end
                    end else begin
                        if (vert) begin
                            r_px1 <= FW'(edge_v) <<< FRAC_BITS;
                            if (den_s == '0) r_py1 <= FW'(base_v) <<< FRAC_BITS;
                        end else begin
                            r_py1 <= FW'(edge_v) <<< FRAC_BITS;
                            if (den_s == '0) r_px1 <= FW'(base_v) <<< FRAC_BITS;
                        end
                    end
                end
            end
            S_MUL: r_prod <= PW'(r_num_mag * r_del_mag);
            S_DIV: if (div_done) begin
                unique case ({r_k, r_vert})
                    2'b00: r_px0 <= cross_res;
                    2'b01: r_py0 <= cross_res;
                    2'b10: r_px1 <= cross_res;
                    2'b11: r_py1 <= cross_res;
                    default: r_px0 <= r_px0;
                endcase
            end
            S_OUT: begin
                r_ox0  <= r_visible ? r_px0 : '0;
                r_oy0  <= r_visible ? r_py0 : '0;
                r_ox1  <= r_visible ? r_px1 : '0;
                r_oy1  <= r_visible ? r_py1 : '0;
                r_ooc0 <= r_oc0;
                r_ooc1 <= r_oc1;
            end
            default: r_prod <= r_prod;
        endcase
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_valid;
    assign o_visible         = r_ovis;
    assign o_clipped_x_start = r_ox0;
    assign o_clipped_y_start = r_oy0;
    assign o_clipped_x_end   = r_ox1;
    assign o_clipped_y_end   = r_oy1;
    assign o_start_outcode   = r_ooc0;
    assign o_end_outcode     = r_ooc1;

    // Visible flag latched with the result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) r_ovis <= r_visible;
    end

`ifndef SYNTHESIS
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result beat while busy");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_clipped_x_start == '0 && o_clipped_y_end == '0))
        else $error("rejected segment with nonzero coords");
    a_iter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= CLIP_LIMIT) else $error("edge move count overflow");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
`endif

endmodule

FILE: tb/line_window_clipper_tb.sv
// Self-checking testbench for line_window_clipper: a directed table, then random segments
// against several clip windows, checked against a behavioral clipper or a typed expected result.
// Depends on lwc_pkg and the line_window_clipper RTL.
module line_window_clipper_tb;
    import lwc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 8;
    localparam int XB = CB + FB;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic          visible;
        logic [XB-1:0] xs;
        logic [XB-1:0] ys;
        logic [XB-1:0] xe;
        logic [XB-1:0] ye;
        logic [3:0]    oc_s;
        logic [3:0]    oc_e;
    } t_clip_res;

    typedef struct {
        logic [CB-1:0] xs, ys, xe, ye;
        bit            typed;
        t_clip_res     res;
    } t_seg_row;

    logic i_clk, i_rst_n, start, busy;
    logic signed [CB-1:0] i_x_start, i_y_start, i_x_end, i_y_end;
    logic o_valid, o_visible;
    logic signed [XB-1:0] o_clipped_x_start, o_clipped_y_start;
    logic signed [XB-1:0] o_clipped_x_end, o_clipped_y_end;
    logic [3:0] o_start_outcode, o_end_outcode;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [CB-1:0] i_cfg_data;

    line_window_clipper #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (.*);

    // window copy used by the predictor
    longint win_left = 50, win_bottom = 50, win_right = 200, win_top = 200;

    t_clip_res pending_clips[$];
    t_seg_row  dir_rows[$];
    int        errors = 0;
    int        stall_cnt = 0;
    int        idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned window_code(longint x, longint y);
        int unsigned c = 0;
        if (y > win_top * 256)    c |= OC_TOP;
        if (y < win_bottom * 256) c |= OC_BOTTOM;
        if (x > win_right * 256)  c |= OC_RIGHT;
        if (x < win_left * 256)   c |= OC_LEFT;
        return c;
    endfunction

    // base*2^F + trunc(num*delta*2^F/den), wrapped to XB bits
    function automatic longint edge_cross(longint base, longint num, longint delta, longint den);
        longint unsigned mn, md, mq, q;
        longint r;
        logic signed [XB-1:0] w;
        bit neg;
        r = base * 256;
        if (den != 0) begin
            mn = (num < 0) ? -num : num;
            md = (delta < 0) ? -delta : delta;
            mq = (den < 0) ? -den : den;
            neg = ((num < 0) != (delta < 0)) != (den < 0);
            q = ((mn * md) << FB) / mq;
            r = neg ? r - longint'(q) : r + longint'(q);
        end
        w = r[XB-1:0];
        return longint'(w);
    endfunction

    function automatic t_clip_res clip_segment(logic signed [CB-1:0] xs,
                                               logic signed [CB-1:0] ys,
                                               logic signed [CB-1:0] xe,
                                               logic signed [CB-1:0] ye);
        t_clip_res r;
        longint px[2], py[2];
        longint dx, dy;
        int unsigned c0, c1, c;
        int k;
        bit vis = 0;
        dx = longint'(xe) - longint'(xs);
        dy = longint'(ye) - longint'(ys);
        px[0] = longint'(xs) * 256; py[0] = longint'(ys) * 256;
        px[1] = longint'(xe) * 256; py[1] = longint'(ye) * 256;
        r.oc_s = 4'(window_code(px[0], py[0]));
        r.oc_e = 4'(window_code(px[1], py[1]));
        for (int i = 0; i <= CLIP_LIMIT; i++) begin
            c0 = window_code(px[0], py[0]);
            c1 = window_code(px[1], py[1]);
            if ((c0 | c1) == 0) begin
                vis = 1;
                break;
            end
            if ((c0 & c1) != 0 || i == CLIP_LIMIT) break;
            k = (c0 != 0) ? 0 : 1;
            c = (k == 0) ? c0 : c1;
            if (c & OC_TOP) begin
                py[k] = win_top * 256;
                px[k] = edge_cross(xs, dx, win_top - ys, dy);
            end else if (c & OC_BOTTOM) begin
                py[k] = win_bottom * 256;
                px[k] = edge_cross(xs, dx, win_bottom - ys, dy);
            end else if (c & OC_RIGHT) begin
                px[k] = win_right * 256;
                py[k] = edge_cross(ys, dy, win_right - xs, dx);
            end else begin
                px[k] = win_left * 256;
                py[k] = edge_cross(ys, dy, win_left - xs, dx);
            end
        end
        r.visible = vis;
        r.xs = vis ? px[0][XB-1:0] : '0;
        r.ys = vis ? py[0][XB-1:0] : '0;
        r.xe = vis ? px[1][XB-1:0] : '0;
        r.ye = vis ? py[1][XB-1:0] : '0;
        return r;
    endfunction

    // accepted input beats, result beats and the stall watchdog
    bit        typed_now = 0;
    t_clip_res typed_res;
    always @(posedge i_clk) begin
        t_clip_res got, want;
        bit        acc;
        if (i_rst_n) begin
            acc = 1'b0;
            if (start && !busy) begin
                pending_clips.push_back(typed_now ? typed_res
                    : clip_segment(i_x_start, i_y_start, i_x_end, i_y_end));
                acc = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) acc = 1'b1;
            if (o_valid) begin
                acc = 1'b1;
                got = '{o_visible, o_clipped_x_start, o_clipped_y_start, o_clipped_x_end,
                        o_clipped_y_end, o_start_outcode, o_end_outcode};
                if (pending_clips.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = pending_clips.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp vis=%b %h %h %h %h oc=%h/%h",
                                      " got vis=%b %h %h %h %h oc=%h/%h"},
                                     want.visible, want.xs, want.ys, want.xe, want.ye,
                                     want.oc_s, want.oc_e, got.visible, got.xs, got.ys,
                                     got.xe, got.ye, got.oc_s, got.oc_e);
                    end
                end
            end
            stall_cnt <= acc ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("[line_window_clipper] ERROR");
                $finish;
            end
        end
    end

    // one input beat; start stays high if the next beat follows at once
    task automatic send_seg(logic [CB-1:0] xs, ys, xe, ye, bit typed, t_clip_res res);
        bit took;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_x_start = xs; i_y_start = ys; i_x_end = xe; i_y_end = ye;
        typed_now = typed; typed_res = res;
        start = 1'b1;
        do begin
            @(posedge i_clk);
            took = !busy;
            @(negedge i_clk);
        end while (!took);
    endtask

    // wait until every result is in and the block is quiet
    task automatic drain();
        start = 1'b0;
        while (pending_clips.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_window(logic [1:0] idx, logic [CB-1:0] val);
        bit took;
        i_cfg_index = idx; i_cfg_data = val; i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
            took = o_cfg_ready;
            @(negedge i_clk);
        end while (!took);
        i_cfg_valid = 1'b0;
        case (idx)
            REG_LEFT:   win_left   = longint'($signed(val));
            REG_BOTTOM: win_bottom = longint'($signed(val));
            REG_RIGHT:  win_right  = longint'($signed(val));
            default:    win_top    = longint'($signed(val));
        endcase
    endtask

    task automatic set_window(logic [CB-1:0] l, b, r, t);
        write_window(REG_LEFT, l);
        write_window(REG_BOTTOM, b);
        write_window(REG_RIGHT, r);
        write_window(REG_TOP, t);
    endtask

    function automatic logic [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom());
            1: return CB'(win_left + $urandom_range(0, 40) - 20);
            2: return CB'($urandom_range(0, 300) - 50);
            default: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
        endcase
    endfunction

    task automatic add_row(logic [CB-1:0] xs, ys, xe, ye);
        t_seg_row r;
        r.xs = xs; r.ys = ys; r.xe = xe; r.ye = ye; r.typed = 0; r.res = '0;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_seg_row row;
        int m;
        start = 0; i_x_start = 0; i_y_start = 0; i_x_end = 0; i_y_end = 0;
        i_cfg_valid = 0; i_cfg_index = REG_LEFT; i_cfg_data = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: typed rows use the reset window 50..200
        row = '{60, 60, 100, 100, 1,
                '{1'b1, 24'd15360, 24'd15360, 24'd25600, 24'd25600, 4'd0, 4'd0}};
        dir_rows.push_back(row);
        row = '{0, 0, 10, 10, 1,
                '{1'b0, 24'd0, 24'd0, 24'd0, 24'd0, OC_BOTTOM | OC_LEFT, OC_BOTTOM | OC_LEFT}};
        dir_rows.push_back(row);
        row = '{50, 50, 200, 200, 1,
                '{1'b1, 24'd12800, 24'd12800, 24'd51200, 24'd51200, 4'd0, 4'd0}};
        dir_rows.push_back(row);
        add_row(0, 100, 300, 100);             // crosses left and right
        add_row(100, 0, 100, 300);             // crosses bottom and top
        add_row(0, 0, 300, 300);               // diagonal through corners
        add_row(10, 150, 150, 260);            // corner miss candidate
        add_row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        add_row(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_row(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_row(120, 120, 120, 120);           // single point inside
        add_row(0, 120, 0, 120);               // single point outside
        add_row(250, 120, 120, 120);           // end inside, start outside
        add_row(120, 120, 120, 250);
        add_row(30, 30, 220, 199);
        add_row(201, 199, 49, 51);
        foreach (dir_rows[i])
            send_seg(dir_rows[i].xs, dir_rows[i].ys, dir_rows[i].xe, dir_rows[i].ye,
                     dir_rows[i].typed, dir_rows[i].res);
        drain();

        // random phases, each with its own window
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_window(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
                1: set_window(-16'sd10, 20, 90, 140);
                2: set_window(200, 200, 50, 50);            // inverted
                3: set_window(CB'($urandom()), CB'($urandom()), CB'($urandom()),
                              CB'($urandom()));
                4: set_window(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
                default: set_window(50, 50, 200, 200);
            endcase
            idle_pct = (ph % 3 == 1) ? 61 : (ph % 3 == 2) ? 35 : 0;
            for (int n = 0; n < 280; n++) begin
                m = (ph == 3 || ph == 4) ? 0 : $urandom_range(0, 9);
                m = (m >= 7) ? 0 : (m == 6) ? 3 : (m >= 3) ? 2 : 1;
                send_seg(rand_coord(m), rand_coord(m == 1 ? 2 : m), rand_coord(m),
                         rand_coord(m == 1 ? 2 : m), 0, '0);
            end
            drain();
        end

        if (errors == 0) $display("[line_window_clipper] OK");
        else $display("[line_window_clipper] ERROR");
        $finish;
    end

endmodule
